### design/rfa_pkg.sv
// Shared types and constants for the reference-counted frame allocator.
package rfa_pkg;

	localparam int ADDR_W         = 48;
	localparam int COUNT_W        = 8;
	localparam int FRAME_SHIFT    = 12;
	localparam int NUM_FRAMES_DEF = 4096;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESCAN = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_UNDER = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_UPDATE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] frame_addr;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  result_addr;
		logic [COUNT_W-1:0] ref_count;
		status_t            status;
	} out_item_t;

endpackage

### design/rfa_count_ram.sv
// Reference count store: one write port, one registered read port.
module rfa_count_ram #(
	parameter int NUM_FRAMES = rfa_pkg::NUM_FRAMES_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(NUM_FRAMES)-1:0]    waddr,
	input  logic [rfa_pkg::COUNT_W-1:0]      wdata,
	input  logic [$clog2(NUM_FRAMES)-1:0]    raddr,
	output logic [rfa_pkg::COUNT_W-1:0]      rdata
);

	logic [rfa_pkg::COUNT_W-1:0] mem [NUM_FRAMES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/rfa_engine.sv
// Sequencer with the shared address adder and count step unit.
module rfa_engine #(
	parameter int NUM_FRAMES = rfa_pkg::NUM_FRAMES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  rfa_pkg::in_item_t                 item,
	input  logic [rfa_pkg::ADDR_W-1:0]        frame_base,
	output logic                              idle,
	output logic                              mem_we,
	output logic [$clog2(NUM_FRAMES)-1:0]     mem_waddr,
	output logic [rfa_pkg::COUNT_W-1:0]       mem_wdata,
	output logic [$clog2(NUM_FRAMES)-1:0]     mem_raddr,
	input  logic [rfa_pkg::COUNT_W-1:0]       mem_rdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output rfa_pkg::out_item_t                res
);

	localparam int IDX_W  = $clog2(NUM_FRAMES);
	localparam int PTR_W  = $clog2(NUM_FRAMES + 1);
	localparam int AW     = rfa_pkg::ADDR_W;
	localparam int CW     = rfa_pkg::COUNT_W;
	localparam int SH     = rfa_pkg::FRAME_SHIFT;
	localparam int HI_W   = AW - SH;
	localparam logic [PTR_W-1:0] FULL_PTR = PTR_W'(NUM_FRAMES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

	rfa_pkg::state_t  state_q, state_d;
	rfa_pkg::op_t     op_q, op_d;
	logic [AW-1:0]    faddr_q, faddr_d;
	logic [AW-1:0]    sum_q, sum_d;
	logic [PTR_W-1:0] nf_q, nf_d;
	logic [PTR_W-1:0] hw_q, hw_d;
	logic [PTR_W-1:0] chk_q, chk_d;
	logic [PTR_W-1:0] end_q, end_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] clr_q, clr_d;
	rfa_pkg::out_item_t res_q, res_d;

	// Shared 48-bit adder: frame address on alloc, base offset otherwise.
	logic          is_alloc;
	logic [AW-1:0] add_a, add_b, sum;
	logic          in_range;

	assign is_alloc = (op_q == rfa_pkg::OP_ALLOC);
	assign add_a    = is_alloc ? frame_base : faddr_q;
	assign add_b    = is_alloc ? {{(AW-PTR_W-SH){1'b0}}, nf_q, {SH{1'b0}}} : ~frame_base;
	assign sum      = add_a + add_b + {{(AW-1){1'b0}}, ~is_alloc};
	assign in_range = (sum[AW-1:SH] < HI_W'(NUM_FRAMES));

	// Shared count step: increment by one that saturates at the maximum, or decrement by one.
	logic          is_dec;
	logic [CW-1:0] stepped, new_cnt;
	logic          cnt_zero;

	assign is_dec   = (op_q == rfa_pkg::OP_FREE);
	assign stepped  = mem_rdata + (is_dec ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1});
	assign new_cnt  = (!is_dec && (mem_rdata == {CW{1'b1}})) ? mem_rdata : stepped;
	assign cnt_zero = (mem_rdata == '0);

	// Rescan window end, exclusive: min(high_water + 1, NUM_FRAMES - 1) + 1.
	logic [PTR_W:0] lim;
	logic [PTR_W:0] rescan_end;

	assign lim        = {1'b0, hw_q} + {{PTR_W{1'b0}}, 1'b1};
	assign rescan_end = (lim > (PTR_W+1)'(NUM_FRAMES - 1)) ?
	                    (PTR_W+1)'(NUM_FRAMES) : lim + {{PTR_W{1'b0}}, 1'b1};

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		faddr_d   = faddr_q;
		sum_d     = sum_q;
		nf_d      = nf_q;
		hw_d      = hw_q;
		chk_d     = chk_q;
		end_d     = end_q;
		idx_d     = idx_q;
		clr_d     = clr_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = new_cnt;
		mem_raddr = idx_q;
		res_valid = 1'b0;

		case (state_q)
			rfa_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == LAST_IDX) begin
					state_d = rfa_pkg::S_IDLE;
				end
			end
			rfa_pkg::S_IDLE: begin
				if (start) begin
					op_d    = item.op;
					faddr_d = item.frame_addr;
					state_d = rfa_pkg::S_DECODE;
				end
			end
			rfa_pkg::S_DECODE: begin
				res_d = '{result_addr: '0, ref_count: '0, status: rfa_pkg::ST_OK};
				case (op_q)
					rfa_pkg::OP_ALLOC: begin
						if (nf_q == FULL_PTR) begin
							res_d.status = rfa_pkg::ST_FULL;
							state_d      = rfa_pkg::S_DONE;
						end else begin
							idx_d     = nf_q[IDX_W-1:0];
							mem_raddr = nf_q[IDX_W-1:0];
							sum_d     = sum;
							state_d   = rfa_pkg::S_UPDATE;
						end
					end
					rfa_pkg::OP_RESCAN: begin
						mem_raddr = '0;
						chk_d     = '0;
						end_d     = rescan_end[PTR_W-1:0];
						state_d   = rfa_pkg::S_SCAN;
					end
					default: begin
						if (!in_range) begin
							res_d.status = rfa_pkg::ST_RANGE;
							state_d      = rfa_pkg::S_DONE;
						end else begin
							idx_d     = sum[SH +: IDX_W];
							mem_raddr = sum[SH +: IDX_W];
							state_d   = rfa_pkg::S_UPDATE;
						end
					end
				endcase
			end
			rfa_pkg::S_UPDATE: begin
				case (op_q)
					rfa_pkg::OP_ALLOC: begin
						mem_we    = 1'b1;
						res_d     = '{result_addr: sum_q, ref_count: new_cnt,
						              status: rfa_pkg::ST_OK};
						// start the walk just past the frame handed out
						mem_raddr = idx_q + 1'b1;
						chk_d     = {{(PTR_W-IDX_W){1'b0}}, idx_q} + 1'b1;
						end_d     = FULL_PTR;
						state_d   = rfa_pkg::S_SCAN;
					end
					rfa_pkg::OP_FREE: begin
						if (cnt_zero) begin
							res_d.status = rfa_pkg::ST_UNDER;
						end else begin
							mem_we          = 1'b1;
							res_d.ref_count = new_cnt;
						end
						state_d = rfa_pkg::S_DONE;
					end
					default: begin
						res_d.ref_count = mem_rdata;
						state_d         = rfa_pkg::S_DONE;
					end
				endcase
			end
			rfa_pkg::S_SCAN: begin
				// read ahead one entry while checking the current one
				mem_raddr = chk_q[IDX_W-1:0] + 1'b1;
				chk_d     = chk_q + 1'b1;
				if (chk_q == end_q) begin
					nf_d = FULL_PTR;
					if (is_alloc) begin
						hw_d = FULL_PTR;
					end else begin
						res_d.status = rfa_pkg::ST_FULL;
					end
					state_d = rfa_pkg::S_DONE;
				end else if (cnt_zero) begin
					nf_d = chk_q;
					if (is_alloc && (chk_q > hw_q)) begin
						hw_d = chk_q;
					end
					state_d = rfa_pkg::S_DONE;
				end
			end
			rfa_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = rfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rfa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::S_CLEAR;
			nf_q    <= '0;
			hw_q    <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			nf_q    <= nf_d;
			hw_q    <= hw_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		faddr_q <= faddr_d;
		sum_q   <= sum_d;
		chk_q   <= chk_d;
		end_q   <= end_d;
		idx_q   <= idx_d;
		res_q   <= res_d;
	end

	assign idle = (state_q == rfa_pkg::S_IDLE);
	assign res  = res_q;

endmodule

### design/refcounted_frame_allocator.sv
// Top level of the reference-counted page frame allocator.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------
//   in       | in        | in_valid / in_stall   | in_item  (op, frame_addr)
//   out      | out       | out_valid / out_stall | out_item (result_addr, ref_count,
//            |           |                       |           status)
//   cfg      | in        | cfg_wen               | cfg_wdata (frame_base)
//
// Sequence: every item is decoded first; free and query then read the count store,
// free writes it back, alloc updates its frame and scans on for the next free one, and
// rescan scans the store; an out-of-range address or a full pool goes to the result.
// The single read port of the count store sets the pace: one entry per cycle.
// Reset: after arst_n is released a clearing pass writes zero to all NUM_FRAMES
// entries, one per cycle, with in_stall high; cfg writes are taken throughout.
// Stalls: a finished item sits in the output register while the next item is
// accepted; the sequencer holds its result only if that register is still full.
module refcounted_frame_allocator #(
	parameter int NUM_FRAMES = rfa_pkg::NUM_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rfa_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rfa_pkg::out_item_t            out_item,
	input  logic                          cfg_wen,
	input  logic [rfa_pkg::ADDR_W-1:0]    cfg_wdata
);

	localparam int IDX_W = $clog2(NUM_FRAMES);

	logic [rfa_pkg::ADDR_W-1:0]  frame_base_q;
	logic                        eng_idle;
	logic                        accept;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [IDX_W-1:0]            mem_raddr;
	logic [rfa_pkg::COUNT_W-1:0] mem_wdata;
	logic [rfa_pkg::COUNT_W-1:0] mem_rdata;
	logic                        res_valid;
	logic                        res_ready;
	rfa_pkg::out_item_t          res;
	logic                        out_valid_q;
	rfa_pkg::out_item_t          out_q;

	// Hold the base register; the user must change it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
		end else if (cfg_wen) begin
			frame_base_q <= cfg_wdata;
		end
	end

	// Stall input while the sequencer works on an item or clears the store.
	assign in_stall = !eng_idle;
	assign accept   = in_valid && !in_stall;

	rfa_count_ram #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rfa_engine #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.item       (in_item),
		.frame_base (frame_base_q),
		.idle       (eng_idle),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register: load when empty or when its item leaves this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The sequencer is busy in the cycle after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after accept");

	// A handed-over result shows up on the output unchanged.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (out_valid && (out_item == $past(res))))
		else $error("result lost between sequencer and output register");

	// Only a successful alloc carries an address.
	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.status != rfa_pkg::ST_OK)) |-> (out_item.result_addr == '0))
		else $error("address on a failed item");

endmodule
